[hdl/button_click_hold_classifier_assert.svh]
// Assertion macros for the button classifier RTL.
// Used by hdl/button_click_hold_classifier.sv; needs clk_i and rst_ni in scope.
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while the block is out of reset.
`define BCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define BCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BCC_ASSERT(label, prop, msg)
`define BCC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/bcc_pkg.sv]
// Shared types and constants of the button click / hold classifier.
// No dependencies; imported by bcc_regs and button_click_hold_classifier.
package bcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned EvW   = 3;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [EvW-1:0] {
    EV_NONE      = 3'd0,
    EV_CLICK     = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_HOLD      = 3'd3,
    EV_LONG_HOLD = 3'd4
  } bcc_event_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_DBL_GAP   = 2'd1,
    REG_HOLD      = 2'd2,
    REG_LONG_HOLD = 2'd3
  } bcc_reg_e;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd20;
  localparam logic [CfgW-1:0] DblGapRst    = 16'd250;
  localparam logic [CfgW-1:0] HoldRst      = 16'd1000;
  localparam logic [CfgW-1:0] LongHoldRst  = 16'd3000;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] double_click_gap_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] long_hold_ms;
  } bcc_cfg_t;

endpackage

[hdl/bcc_regs.sv]
// APB-style register file holding the four timing thresholds.
// Depends on bcc_pkg for the register map and the configuration struct.
module bcc_regs import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output bcc_cfg_t         cfg_o
);

  bcc_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  bcc_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = bcc_reg_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DEBOUNCE:  cfg_d.debounce_ms         = pwdata[CfgW-1:0];
        REG_DBL_GAP:   cfg_d.double_click_gap_ms = pwdata[CfgW-1:0];
        REG_HOLD:      cfg_d.hold_ms             = pwdata[CfgW-1:0];
        REG_LONG_HOLD: cfg_d.long_hold_ms        = pwdata[CfgW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:  prdata = DataW'(cfg_q.debounce_ms);
      REG_DBL_GAP:   prdata = DataW'(cfg_q.double_click_gap_ms);
      REG_HOLD:      prdata = DataW'(cfg_q.hold_ms);
      REG_LONG_HOLD: prdata = DataW'(cfg_q.long_hold_ms);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= DebounceRst;
      cfg_q.double_click_gap_ms <= DblGapRst;
      cfg_q.hold_ms             <= HoldRst;
      cfg_q.long_hold_ms        <= LongHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/button_click_hold_classifier.sv]
// Top level of the button click / double click / hold classifier.
// Depends on bcc_pkg, bcc_regs and button_click_hold_classifier_assert.svh.
//
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_ready_o   pin_level_i, now_ms_i
// out       output     out_valid_o / out_ready_i event_code_o, shutting_down_o
// cfg       input      APB psel/penable/pwrite   paddr (4 bits), pwdata/prdata (32 bits)
//
// One word is accepted per clock cycle when the output side keeps up. Each
// poll is accepted into the input register; once the result register is
// free, the poll is classified and its result is registered there to leave.
// The rate is set by the single classification step between those two
// registers, which updates the button state once per word.
// Reset (rst_ni low, asynchronous) clears both stages and restores the
// thresholds to 20, 250, 1000 and 3000 ms. When out_ready_i is low the
// result register holds its word, the input register fills, and in_ready_o
// drops only once both are occupied.
`include "button_click_hold_classifier_assert.svh"

module button_click_hold_classifier import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // poll input
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             pin_level_i,
  input  logic [TimeW-1:0] now_ms_i,
  // event output
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [EvW-1:0]   event_code_o,
  output logic             shutting_down_o,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  bcc_cfg_t cfg;

  bcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage one: the accepted poll waits here until the result register is free.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_level_q;
  logic [TimeW-1:0] s1_now_q;
  logic             s1_adv;
  logic             in_acc;

  // Stage two: the result register. The button state below always reflects
  // the poll whose result sits here (or the last one delivered).
  logic             out_valid_q, out_valid_d;
  bcc_event_e       ev_q, ev_d;
  logic             shut_q, shut_d;

  logic             last_level_q, last_level_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] release_time_q, release_time_d;
  logic             ignore_release_q, ignore_release_d;
  logic             single_allowed_q, single_allowed_d;
  logic             hold_reported_q, hold_reported_d;
  logic             long_reported_q, long_reported_d;
  logic             dbl_on_release_q, dbl_on_release_d;
  logic             dbl_waiting_q, dbl_waiting_d;

  logic [TimeW-1:0] since_rel, since_prs, since_rel2, since_prs2;
  logic [TimeW-1:0] debounce, gap, hold_thr, long_thr;
  logic             press_acc, rel_acc, rel_taken;

  // The stage one word moves on when the result register is empty or drained.
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  assign s1_valid_d  = in_acc | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & ~out_ready_i);

  assign debounce = TimeW'(cfg.debounce_ms);
  assign gap      = TimeW'(cfg.double_click_gap_ms);
  assign hold_thr = TimeW'(cfg.hold_ms);
  assign long_thr = TimeW'(cfg.long_hold_ms);

  // Elapsed times wrap naturally in 32-bit arithmetic.
  assign since_rel = s1_now_q - release_time_q;
  assign since_prs = s1_now_q - press_time_q;

  // A press edge counts only if the last release is more than the debounce
  // time back, and likewise for a release edge against the last press.
  assign press_acc = ~s1_level_q & last_level_q & (since_rel > debounce);
  assign rel_acc   = s1_level_q & ~last_level_q & (since_prs > debounce);
  assign rel_taken = rel_acc & ~ignore_release_q;

  // After an accepted edge its own timestamp becomes the reference, so the
  // elapsed time restarts at zero without a second subtraction.
  assign since_rel2 = rel_taken ? '0 : since_rel;
  assign since_prs2 = press_acc ? '0 : since_prs;

  always_comb begin
    ev_d             = EV_NONE;
    last_level_d     = s1_level_q;
    press_time_d     = press_time_q;
    release_time_d   = release_time_q;
    ignore_release_d = ignore_release_q;
    single_allowed_d = single_allowed_q;
    hold_reported_d  = hold_reported_q;
    long_reported_d  = long_reported_q;
    dbl_on_release_d = dbl_on_release_q;
    dbl_waiting_d    = dbl_waiting_q;

    if (press_acc) begin
      press_time_d     = s1_now_q;
      ignore_release_d = 1'b0;
      single_allowed_d = 1'b1;
      hold_reported_d  = 1'b0;
      long_reported_d  = 1'b0;
      // A quick second press after a released first click arms a double click.
      dbl_on_release_d = (since_rel < gap) & ~dbl_on_release_q & dbl_waiting_q;
      dbl_waiting_d    = 1'b0;
    end else if (rel_taken) begin
      release_time_d = s1_now_q;
      if (!dbl_on_release_q) begin
        dbl_waiting_d = 1'b1;
      end else begin
        ev_d             = EV_DOUBLE;
        dbl_on_release_d = 1'b0;
        dbl_waiting_d    = 1'b0;
        single_allowed_d = 1'b0;
      end
    end

    // A single click is reported once the double-click window has closed.
    if (s1_level_q && (since_rel2 >= gap) && dbl_waiting_d && !dbl_on_release_d &&
        single_allowed_d && (ev_d != EV_DOUBLE)) begin
      ev_d          = EV_CLICK;
      dbl_waiting_d = 1'b0;
    end

    // Holds; the long hold wins when both thresholds pass in one poll.
    if (!s1_level_q && (since_prs2 >= hold_thr)) begin
      if (!hold_reported_d) begin
        ev_d             = EV_HOLD;
        ignore_release_d = 1'b1;
        dbl_on_release_d = 1'b0;
        dbl_waiting_d    = 1'b0;
        hold_reported_d  = 1'b1;
      end
      if ((since_prs2 >= long_thr) && !long_reported_d) begin
        ev_d            = EV_LONG_HOLD;
        long_reported_d = 1'b1;
      end
    end

    shut_d = ~s1_level_q & hold_reported_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      last_level_q     <= 1'b1;
      press_time_q     <= '0;
      release_time_q   <= '0;
      ignore_release_q <= 1'b0;
      single_allowed_q <= 1'b0;
      hold_reported_q  <= 1'b0;
      long_reported_q  <= 1'b0;
      dbl_on_release_q <= 1'b0;
      dbl_waiting_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        last_level_q     <= last_level_d;
        press_time_q     <= press_time_d;
        release_time_q   <= release_time_d;
        ignore_release_q <= ignore_release_d;
        single_allowed_q <= single_allowed_d;
        hold_reported_q  <= hold_reported_d;
        long_reported_q  <= long_reported_d;
        dbl_on_release_q <= dbl_on_release_d;
        dbl_waiting_q    <= dbl_waiting_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_level_q <= pin_level_i;
      s1_now_q   <= now_ms_i;
    end
    if (s1_adv) begin
      ev_q   <= ev_d;
      shut_q <= shut_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = ev_q;
  assign shutting_down_o = shut_q;

  // The shutdown flag must agree with the state left by the same poll.
  `BCC_ASSERT(a_shut_state, out_valid_q && shut_q |-> hold_reported_q && !last_level_q, "shutdown flag without a reported hold")
  // A hold report always blocks the click from the coming release.
  `BCC_ASSERT(a_hold_ignores, out_valid_q && (ev_q == EV_HOLD || ev_q == EV_LONG_HOLD) |-> hold_reported_q && ignore_release_q, "hold reported without release masking")
  // A long hold leaves its own flag set.
  `BCC_ASSERT(a_long_flag, out_valid_q && ev_q == EV_LONG_HOLD |-> long_reported_q, "long hold without its flag")
  // A double click consumes the pending single click.
  `BCC_ASSERT(a_double_clears, out_valid_q && ev_q == EV_DOUBLE |-> !single_allowed_q && !dbl_on_release_q && !dbl_waiting_q, "double click left click state armed")
  // Button state only changes when a word enters the result register.
  `BCC_ASSERT(a_state_hold, !$past(s1_adv) |-> $stable(press_time_q) && $stable(release_time_q), "button state changed without a poll")

endmodule
